@@ design/multi_tap_echo_macros.svh @@
// Assertion macros for the multi-tap echo block.
// Used by the top level; expects signals clk and rst in scope.
`ifndef MULTI_TAP_ECHO_MACROS_SVH
`define MULTI_TAP_ECHO_MACROS_SVH

// same-cycle implication, checked outside reset
`define MTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, checked outside reset
`define MTE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ design/mte_pkg.sv @@
// Shared types and constants of the multi-tap echo block.
// No dependencies.
package mte_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DELAY_W   = 14;
  localparam int COEF_W    = 15;
  localparam int FRAC      = 14;
  localparam int ACC_W     = 20;
  localparam int PROD_W    = ACC_W + COEF_W + 1;
  localparam int TRUNC_W   = PROD_W - FRAC;
  localparam int TAP_SLOTS = 8;
  localparam int TAP_IDX_W = 3;
  localparam int APB_AW    = 6;
  localparam int APB_DW    = 64;

  localparam logic signed [TRUNC_W-1:0] SAT_MAX = TRUNC_W'(32767);
  localparam logic signed [TRUNC_W-1:0] SAT_MIN = -TRUNC_W'(32768);

  typedef enum logic [2:0] {
    REG_IN_GAIN      = 3'd0,
    REG_OUT_GAIN     = 3'd1,
    REG_TAP_COUNT    = 3'd2,
    REG_DELAYS_LOW   = 3'd3,
    REG_DELAYS_HIGH  = 3'd4,
    REG_DECAYS_LOW   = 3'd5,
    REG_DECAYS_HIGH  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_GAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               vld;
    logic [DELAY_W-1:0] delay;
  } rd_req_t;

endpackage

@@ design/mte_ring.sv @@
// History ring of the multi-tap echo: sample memory, write pointer, fill count.
// Depends on mte_pkg.
module mte_ring #(
  parameter int RING_DEPTH = 8192
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mte_pkg::rd_req_t                     rd_req,
  input  logic                                 wr_en,
  input  logic signed [mte_pkg::SAMPLE_W-1:0]  wr_data,
  output logic                                 rd_vld,
  output logic signed [mte_pkg::SAMPLE_W-1:0]  rd_data
);
  import mte_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = ((CNT_W > DELAY_W) ? CNT_W : DELAY_W) + 1;

  logic signed [SAMPLE_W-1:0] mem [RING_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_raw;
  logic                       rd_zero;
  logic [PTR_W-1:0]           wp;
  logic [CNT_W-1:0]           filled;

  logic [SUM_W-1:0] d_ext;
  logic [SUM_W-1:0] d_eff;
  logic [SUM_W-1:0] depth_ext;
  logic [SUM_W-1:0] sum;
  logic [PTR_W-1:0] rd_addr;
  logic             unwritten;

  always_comb begin
    depth_ext = SUM_W'(RING_DEPTH);
    d_ext     = SUM_W'(rd_req.delay);
    if (d_ext == '0) begin
      d_eff = SUM_W'(1);
    end else if (d_ext > depth_ext) begin
      d_eff = depth_ext;
    end else begin
      d_eff = d_ext;
    end
    sum = SUM_W'(wp) + depth_ext - d_eff;
    if (sum >= depth_ext) begin
      sum = sum - depth_ext;
    end
    rd_addr   = sum[PTR_W-1:0];
    // entries older than the fill count were never written and read as zero
    unwritten = d_eff > SUM_W'(filled);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
    if (rd_req.vld) begin
      rd_raw  <= mem[rd_addr];
      rd_zero <= unwritten;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      filled <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_req.vld;
      if (wr_en) begin
        if (wp == PTR_W'(RING_DEPTH - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + PTR_W'(1);
        end
        if (filled != CNT_W'(RING_DEPTH)) begin
          filled <= filled + CNT_W'(1);
        end
      end
    end
  end

  assign rd_data = rd_zero ? '0 : rd_raw;

endmodule

@@ design/multi_tap_echo.sv @@
// Multi-tap feed-forward echo, top level: config registers, sequencer, shared multiplier.
// Depends on mte_pkg, mte_ring and multi_tap_echo_macros.svh.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: sample_in, tlast: end_of_block
//  m_axis    out        m_axis_tvalid/tready    tdata: sample_out, tlast: end_of_block_out
//  apb       in         psel/penable/pready     7 registers at 8*i, 64-bit data
//
// Each sample runs tap_count taps (tap_count clamped to MAX_TAPS) through
// one multiplier shared by the dry gain, each tap and the output gain.
// Tap reads go through the single ring read port, one per cycle.
// rst clears control state; the ring needs no clearing pass (fill count).
// A finished result waits in the output register; the next sample is taken meanwhile.
`include "multi_tap_echo_macros.svh"

module multi_tap_echo #(
  parameter int RING_DEPTH = 8192,
  parameter int MAX_TAPS   = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [15:0] sample_in
  input  logic                         s_axis_tlast,   // end_of_block
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [15:0] sample_out
  output logic                         m_axis_tlast,   // end_of_block_out
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mte_pkg::APB_AW-1:0]   paddr,
  input  logic [mte_pkg::APB_DW-1:0]   pwdata,
  output logic [mte_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import mte_pkg::*;

  logic [COEF_W-1:0]      in_gain;
  logic [COEF_W-1:0]      post_gain;
  logic [2:0]             tap_count;
  logic [55:0]            tap_delays_low;
  logic [41:0]            tap_delays_high;
  logic [59:0]            tap_decays_low;
  logic [44:0]            tap_decays_high;

  state_t                 state;
  state_t                 state_next;
  logic signed [SAMPLE_W-1:0] x;
  logic                   eob;
  logic [TAP_IDX_W-1:0]   issue_k;
  logic [TAP_IDX_W-1:0]   rd_tap;
  logic                   dry_pending;
  logic signed [PROD_W-1:0] prod;
  logic                   prod_vld;
  logic signed [ACC_W-1:0] acc;
  logic [SAMPLE_W-1:0]    out_data;
  logic                   out_last;
  logic                   out_vld;

  logic [DELAY_W-1:0]     dly [TAP_SLOTS];
  logic [COEF_W-1:0]      dcy [TAP_SLOTS];
  logic [TAP_IDX_W-1:0]   taps_eff;
  logic                   issue_go;
  logic                   in_xfer;
  logic                   out_load;
  logic                   ring_wr;
  logic                   mul_en;
  logic signed [ACC_W-1:0] mul_a;
  logic [COEF_W-1:0]      mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [TRUNC_W-1:0] prod_q;
  logic [SAMPLE_W-1:0]    y_sat;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;
  rd_req_t                rd_req;
  logic                   rd_vld;
  logic signed [SAMPLE_W-1:0] rd_data;

  function automatic logic signed [TRUNC_W-1:0] q14_trunc(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [TRUNC_W-1:0] fl;
    logic                      rnd;
    fl  = p[PROD_W-1:FRAC];
    rnd = p[PROD_W-1] & (|p[FRAC-1:0]);
    return fl + {{(TRUNC_W-1){1'b0}}, rnd};
  endfunction

  // APB registers
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_gain         <= COEF_W'(13107);
      post_gain       <= COEF_W'(14418);
      tap_count       <= 3'd1;
      tap_delays_low  <= 56'd2880;
      tap_delays_high <= '0;
      tap_decays_low  <= 60'd6554;
      tap_decays_high <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IN_GAIN:     in_gain         <= pwdata[COEF_W-1:0];
        REG_OUT_GAIN:    post_gain       <= pwdata[COEF_W-1:0];
        REG_TAP_COUNT:   tap_count       <= pwdata[2:0];
        REG_DELAYS_LOW:  tap_delays_low  <= pwdata[55:0];
        REG_DELAYS_HIGH: tap_delays_high <= pwdata[41:0];
        REG_DECAYS_LOW:  tap_decays_low  <= pwdata[59:0];
        REG_DECAYS_HIGH: tap_decays_high <= pwdata[44:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_IN_GAIN:     prdata = APB_DW'(in_gain);
      REG_OUT_GAIN:    prdata = APB_DW'(post_gain);
      REG_TAP_COUNT:   prdata = APB_DW'(tap_count);
      REG_DELAYS_LOW:  prdata = APB_DW'(tap_delays_low);
      REG_DELAYS_HIGH: prdata = APB_DW'(tap_delays_high);
      REG_DECAYS_LOW:  prdata = APB_DW'(tap_decays_low);
      REG_DECAYS_HIGH: prdata = APB_DW'(tap_decays_high);
      default:         prdata = '0;
    endcase
  end

  // per-tap fields
  for (genvar g = 0; g < TAP_SLOTS; g++) begin : g_tap
    if (g < 4) begin : g_low
      assign dly[g] = tap_delays_low[g*DELAY_W +: DELAY_W];
      assign dcy[g] = tap_decays_low[g*COEF_W +: COEF_W];
    end else if (g < 7) begin : g_high
      assign dly[g] = tap_delays_high[(g-4)*DELAY_W +: DELAY_W];
      assign dcy[g] = tap_decays_high[(g-4)*COEF_W +: COEF_W];
    end else begin : g_none
      assign dly[g] = '0;
      assign dcy[g] = '0;
    end
  end

  assign taps_eff = (tap_count > TAP_IDX_W'(MAX_TAPS)) ? TAP_IDX_W'(MAX_TAPS) : tap_count;

  // sequencer
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    issue_go      = 1'b0;
    ring_wr       = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        issue_go = issue_k < taps_eff;
        if (!dry_pending && !issue_go && !rd_vld && !prod_vld) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        ring_wr    = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_xfer = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign rd_req.vld   = issue_go;
  assign rd_req.delay = dly[issue_k];

  mte_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_req  (rd_req),
    .wr_en   (ring_wr),
    .wr_data (x),
    .rd_vld  (rd_vld),
    .rd_data (rd_data)
  );

  // shared multiplier
  always_comb begin
    if (dry_pending) begin
      mul_a = {{(ACC_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
      mul_b = in_gain;
    end else if (state == ST_GAIN) begin
      mul_a = acc;
      mul_b = post_gain;
    end else begin
      mul_a = {{(ACC_W-SAMPLE_W){rd_data[SAMPLE_W-1]}}, rd_data};
      mul_b = dcy[rd_tap];
    end
    mul_en    = dry_pending | rd_vld | (state == ST_GAIN);
    prod_next = mul_a * $signed({1'b0, mul_b});
  end

  assign prod_q = q14_trunc(prod);

  always_comb begin
    if (prod_q > SAT_MAX) begin
      y_sat = 16'h7fff;
    end else if (prod_q < SAT_MIN) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = prod_q[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x   <= s_axis_tdata;
      eob <= s_axis_tlast;
    end
    if (issue_go) begin
      rd_tap <= issue_k;
    end
    if (mul_en) begin
      prod <= prod_next;
    end
    if (in_xfer) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod_q[ACC_W-1:0];
    end
    if (out_load) begin
      out_data <= y_sat;
      out_last <= eob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_k     <= '0;
      dry_pending <= 1'b0;
      prod_vld    <= 1'b0;
      out_vld     <= 1'b0;
    end else begin
      prod_vld <= dry_pending | rd_vld;
      if (in_xfer) begin
        issue_k     <= '0;
        dry_pending <= 1'b1;
      end else begin
        dry_pending <= 1'b0;
        if (issue_go) begin
          issue_k <= issue_k + TAP_IDX_W'(1);
        end
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

  `MTE_ASSERT_NXT(a_accept_starts_dry, in_xfer, dry_pending && state == ST_RUN)
  `MTE_ASSERT_IMP(a_read_in_run, rd_vld, state == ST_RUN)
  `MTE_ASSERT_IMP(a_prod_in_run, prod_vld, state == ST_RUN)
  `MTE_ASSERT_IMP(a_gain_drained, state == ST_GAIN, !rd_vld && !prod_vld && !dry_pending)
  `MTE_ASSERT_NXT(a_finish_loads, out_load, m_axis_tvalid && state == ST_IDLE)

endmodule

@@ tb/echo_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the multi-tap echo testbench: a bit-exact echo predictor with
// its own registers and history ring, plus the queue of samples still due.
// Depends on mte_pkg.
package echo_check_pkg;
  import mte_pkg::*;

  localparam int RING_DEPTH = 8192;
  localparam int MAX_TAPS = 7;
  localparam longint Q14_ONE = longint'(1) << FRAC;
  localparam logic [2:0] UNMAPPED_REG = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } echo_sample_t;

  class echo_scoreboard;
    bit [COEF_W-1:0]    in_gain;
    bit [COEF_W-1:0]    post_gain;
    bit [2:0]           tap_count;
    bit [4*DELAY_W-1:0] delays_lo;
    bit [3*DELAY_W-1:0] delays_hi;
    bit [4*COEF_W-1:0]  decays_lo;
    bit [3*COEF_W-1:0]  decays_hi;
    logic signed [SAMPLE_W-1:0] history [RING_DEPTH];
    int wr_pos;
    echo_sample_t expected_echoes[$];
    int errors;
    int outputs_seen;

    function new();
      in_gain = 13107;
      post_gain = 14418;
      tap_count = 1;
      delays_lo = 2880;
      delays_hi = 0;
      decays_lo = 6554;
      decays_hi = 0;
      foreach (history[i]) history[i] = '0;
      wr_pos = 0;
      errors = 0;
      outputs_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_IN_GAIN:     in_gain = data[COEF_W-1:0];
        REG_OUT_GAIN:    post_gain = data[COEF_W-1:0];
        REG_TAP_COUNT:   tap_count = data[2:0];
        REG_DELAYS_LOW:  delays_lo = data[4*DELAY_W-1:0];
        REG_DELAYS_HIGH: delays_hi = data[3*DELAY_W-1:0];
        REG_DECAYS_LOW:  decays_lo = data[4*COEF_W-1:0];
        REG_DECAYS_HIGH: decays_hi = data[3*COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // Q1.14 product, truncated toward zero
    function longint q14_scale(longint v, longint g);
      return (v * g) / Q14_ONE;
    endfunction

    function int tap_delay(int k);
      if (k < 4) return delays_lo[DELAY_W*k +: DELAY_W];
      return delays_hi[DELAY_W*(k-4) +: DELAY_W];
    endfunction

    function int tap_decay(int k);
      if (k < 4) return decays_lo[COEF_W*k +: COEF_W];
      return decays_hi[COEF_W*(k-4) +: COEF_W];
    endfunction

    function void predict_echo(logic [SAMPLE_W-1:0] raw, logic last);
      logic signed [SAMPLE_W-1:0] x;
      longint dry;
      longint acc;
      longint y;
      int taps;
      int dly;
      int rd_pos;
      echo_sample_t res;
      x = raw;
      dry = x;
      taps = tap_count;
      if (taps > MAX_TAPS) taps = MAX_TAPS;
      acc = q14_scale(dry, in_gain);
      for (int k = 0; k < taps; k++) begin
        dly = tap_delay(k);
        if (dly == 0) dly = 1;
        if (dly > RING_DEPTH) dly = RING_DEPTH;
        rd_pos = (wr_pos + RING_DEPTH - dly) % RING_DEPTH;
        acc += q14_scale(history[rd_pos], tap_decay(k));
      end
      y = q14_scale(acc, post_gain);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      history[wr_pos] = x;
      wr_pos = (wr_pos + 1) % RING_DEPTH;
      res.sample = y[SAMPLE_W-1:0];
      res.last = last;
      expected_echoes.push_back(res);
    endfunction

    function void check_echo(logic [SAMPLE_W-1:0] sample, logic last);
      echo_sample_t exp_s;
      outputs_seen++;
      if (expected_echoes.size() == 0) begin
        $display("%0t: output transfer with nothing expected: sample %0d last %0b",
                 $time, $signed(sample), last);
        errors++;
        return;
      end
      exp_s = expected_echoes.pop_front();
      if (sample !== exp_s.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time,
                 $signed(exp_s.sample), $signed(sample));
        errors++;
      end
      if (last !== exp_s.last) begin
        $display("%0t: end_of_block_out expected %0b actual %0b", $time, exp_s.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench of multi_tap_echo: stream and APB drivers, monitors, watchdog.
// Depends on mte_pkg, echo_check_pkg and the multi_tap_echo RTL.
module tb;
  import mte_pkg::*;
  import echo_check_pkg::*;

  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 128;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // [15:0] sample_in
  logic                s_axis_tlast = 1'b0; // end_of_block
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // [15:0] sample_out
  logic                m_axis_tlast;        // end_of_block_out
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  echo_scoreboard sb;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  int  idle_cycles = 0;

  multi_tap_echo uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.predict_echo(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_echo(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] s, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= s;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_echoes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COEF_W'(16384);
      default: return COEF_W'($urandom_range(0, 20000));
    endcase
  endfunction

  // mostly short delays so taps hit history written in the same phase
  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return DELAY_W'($urandom_range(8192, 16383));
      2: return DELAY_W'($urandom_range(8191, 8192));
      3: return DELAY_W'($urandom);
      default: return DELAY_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // junk in the unused upper bits checks the register masking
  task automatic random_config();
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[COEF_W-1:0] = pick_coef();
    apb_write(REG_IN_GAIN, d);
    d = {$urandom, $urandom};
    d[COEF_W-1:0] = pick_coef();
    apb_write(REG_OUT_GAIN, d);
    apb_write(REG_TAP_COUNT, {$urandom, $urandom});
    d = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) d[DELAY_W*k +: DELAY_W] = pick_delay();
    apb_write(REG_DELAYS_LOW, d);
    d = {$urandom, $urandom};
    for (int k = 0; k < 3; k++) d[DELAY_W*k +: DELAY_W] = pick_delay();
    apb_write(REG_DELAYS_HIGH, d);
    d = {$urandom, $urandom};
    for (int k = 0; k < 4; k++) d[COEF_W*k +: COEF_W] = pick_coef();
    apb_write(REG_DECAYS_LOW, d);
    d = {$urandom, $urandom};
    for (int k = 0; k < 3; k++) d[COEF_W*k +: COEF_W] = pick_coef();
    apb_write(REG_DECAYS_HIGH, d);
    if ($urandom_range(0, 1) == 1) apb_write(UNMAPPED_REG, {$urandom, $urandom});
  endtask

  initial begin
    int seg;
    int mode;
    int beat;
    int next_hold;
    next_hold = 200;
    beat = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      seg = $urandom_range(16, 256);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        if (sb.outputs_seen >= next_hold) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          next_hold += 700;
        end
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (beat % 3 != 0);
        endcase
        beat++;
        @(posedge clk);
      end
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset configuration
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_idle();

    // all gains at max, zero and long delays, saturation both ways
    apb_write(REG_IN_GAIN, '1);
    apb_write(REG_OUT_GAIN, '1);
    apb_write(REG_TAP_COUNT, '1);
    apb_write(REG_DELAYS_LOW, {8'hFF, 14'd8192, 14'd16383, 14'd1, 14'd0});
    apb_write(REG_DELAYS_HIGH, {22'h3FFFFF, 14'd3, 14'd8191, 14'd2});
    apb_write(REG_DECAYS_LOW, '1);
    apb_write(REG_DECAYS_HIGH, {19'h7FFFF, 15'd32767, 15'd0, 15'd16384});
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h3039, 1'b0);
    send_sample(16'hCFC7, 1'b1);
    wait_idle();

    // no taps, unity gains; out-of-range register write ignored
    apb_write(REG_IN_GAIN, 64'hFFFF_FFFF_FFFF_C000);
    apb_write(REG_OUT_GAIN, 64'h0000_0000_0000_4000);
    apb_write(REG_TAP_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
    apb_write(UNMAPPED_REG, '1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();

    // tiny gain on negatives: truncation toward zero
    apb_write(REG_IN_GAIN, 64'd1);
    apb_write(REG_TAP_COUNT, 64'd1);
    apb_write(REG_DELAYS_LOW, 64'd1);
    apb_write(REG_DECAYS_LOW, 64'd3);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hEAAB, 1'b0);
    send_sample(16'h1555, 1'b1);
    send_sample(16'h8000, 1'b0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(pick_sample(), ($urandom_range(0, 3) == 0));
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_echoes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mte_pkg.sv
design/mte_ring.sv
design/multi_tap_echo.sv
tb/echo_check_pkg.sv
tb/tb.sv
